// ===== rtl/lmdd_pkg.sv =====
// Shared types, widths and codes of the lock manager with deadlock detection.
package lmdd_pkg;

  localparam int NUM_PROCS = 16;
  localparam int NUM_LOCKS = 16;

  localparam int CMD_W  = 2;
  localparam int ID_W   = 4;
  localparam int ST_W   = 3;
  localparam int PID_W  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int LK_W   = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int QLEN_W = $clog2(NUM_PROCS + 1);
  localparam int STEP_W = PID_W;

  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TRY     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

  localparam logic [ST_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_QUEUED   = 3'd1;
  localparam logic [ST_W-1:0] ST_MEMBER   = 3'd2;
  localparam logic [ST_W-1:0] ST_FREED    = 3'd3;
  localparam logic [ST_W-1:0] ST_HANDED   = 3'd4;
  localparam logic [ST_W-1:0] ST_NOT_OWN  = 3'd5;
  localparam logic [ST_W-1:0] ST_TRY_FAIL = 3'd6;

  // classified request word passed from front to back
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [PID_W-1:0] pid;
    logic [LK_W-1:0]  lk;
  } req_t;

  // queue status seen by the back part
  typedef struct packed {
    logic valid;
    req_t req;
  } req_q_t;

endpackage

// ===== rtl/lock_manager_deadlock_detect.sv =====
// Top level of the lock manager with wait-for deadlock detection.
//
//  channel | ports                                        | direction
//  in      | in_valid in_stall in_command in_process_id in_lock_id | request words in
//  out     | out_valid out_stall out_status out_woken_pid out_member_pid out_last | results out
//
// A request is queued, dispatched and executed when it causes one result.
// An acquire that queues then walks the wait-for chain (up to NUM_PROCS links),
// and on a deadlock marks the members, then emits one result per member.
// Synchronous active-low reset clears the lock tables and all process tables but the link table.
// A stalled output holds the back part; the two-word request queue takes input until it is full.
module lock_manager_deadlock_detect import lmdd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] in_command,
  input  logic [ID_W-1:0]  in_process_id,
  input  logic [ID_W-1:0]  in_lock_id,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ST_W-1:0]  out_status,
  output logic [ID_W-1:0]  out_woken_pid,
  output logic [ID_W-1:0]  out_member_pid,
  output logic             out_last
);

  req_q_t head;
  logic   pop;

  lmdd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_process_id (in_process_id),
    .in_lock_id    (in_lock_id),
    .head          (head),
    .pop           (pop)
  );

  lmdd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_woken_pid  (out_woken_pid),
    .out_member_pid (out_member_pid),
    .out_last       (out_last)
  );

endmodule

// ===== rtl/lmdd_front.sv =====
// Front part: accepts requests, drops unused commands, queues them for the back part.
module lmdd_front import lmdd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] in_command,
  input  logic [ID_W-1:0]  in_process_id,
  input  logic [ID_W-1:0]  in_lock_id,
  output req_q_t           head,
  input  logic             pop
);

  req_t       slot_r [2];
  req_t       slot_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  req_t       word;

  assign in_stall = (cnt_r == 2'd2);

  // classify: fold ids into range, skip the unused command
  always_comb begin
    word.cmd = in_command;
    word.pid = PID_W'(in_process_id % NUM_PROCS);
    word.lk  = LK_W'(in_lock_id % NUM_LOCKS);
  end

  assign push = in_valid && !in_stall && (in_command != CMD_NONE);

  assign head.valid = (cnt_r != 2'd0);
  assign head.req   = slot_r[0];

  // shift queue of two words
  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (pop) begin
      slot_nxt[0] = slot_r[1];
      cnt_nxt     = cnt_nxt - 2'd1;
    end
    if (push) begin
      slot_nxt[1'(cnt_nxt)] = word;
      cnt_nxt               = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/lmdd_back.sv =====
// Back part: lock tables, request execution, wait-for chain walk and member output.
module lmdd_back import lmdd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  req_q_t          head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [ST_W-1:0] out_status,
  output logic [ID_W-1:0] out_woken_pid,
  output logic [ID_W-1:0] out_member_pid,
  output logic            out_last
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_WALK = 5'b00100,
    S_MARK = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // lock tables
  logic [NUM_LOCKS-1:0] held_r, held_nxt;
  logic [PID_W-1:0]  owner_r [NUM_LOCKS];
  logic [PID_W-1:0]  owner_nxt [NUM_LOCKS];
  logic [PID_W-1:0]  qhead_r [NUM_LOCKS];
  logic [PID_W-1:0]  qhead_nxt [NUM_LOCKS];
  logic [PID_W-1:0]  qtail_r [NUM_LOCKS];
  logic [PID_W-1:0]  qtail_nxt [NUM_LOCKS];
  logic [QLEN_W-1:0] qlen_r [NUM_LOCKS];
  logic [QLEN_W-1:0] qlen_nxt [NUM_LOCKS];
  // process tables
  logic [PID_W-1:0]  link_r [NUM_PROCS];
  logic [PID_W-1:0]  link_nxt [NUM_PROCS];
  logic [LK_W-1:0]   wlock_r [NUM_PROCS];
  logic [LK_W-1:0]   wlock_nxt [NUM_PROCS];
  logic [NUM_PROCS-1:0] waiting_r, waiting_nxt;
  logic [NUM_PROCS-1:0] dead_r, dead_nxt;

  // request and walk registers
  req_t                 req_r, req_nxt;
  logic [PID_W-1:0]     p_r, p_nxt;
  logic [LK_W-1:0]      l_r, l_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [NUM_PROCS-1:0] seen_r, seen_nxt;

  // output register
  logic            ovalid_r, ovalid_nxt;
  logic [ST_W-1:0] ostatus_r, ostatus_nxt;
  logic [ID_W-1:0] owoken_r, owoken_nxt;
  logic [ID_W-1:0] omember_r, omember_nxt;
  logic            olast_r, olast_nxt;

  logic             slot_free;
  logic [PID_W-1:0] own;
  logic [PID_W-1:0] h;
  logic [PID_W-1:0] low_idx;
  logic [NUM_PROCS-1:0] seen_left;

  assign out_valid      = ovalid_r;
  assign out_status     = ostatus_r;
  assign out_woken_pid  = owoken_r;
  assign out_member_pid = omember_r;
  assign out_last       = olast_r;

  assign slot_free = !ovalid_r || !out_stall;
  assign own       = owner_r[l_r];
  assign h         = qhead_r[req_r.lk];

  // find lowest remaining member
  always_comb begin
    low_idx = '0;
    for (int i = NUM_PROCS - 1; i >= 0; i--) begin
      if (seen_r[i]) low_idx = PID_W'(i);
    end
  end

  assign seen_left = seen_r & ~(NUM_PROCS'(1) << low_idx);

  always_comb begin
    state_nxt   = state_r;
    held_nxt    = held_r;
    owner_nxt   = owner_r;
    qhead_nxt   = qhead_r;
    qtail_nxt   = qtail_r;
    qlen_nxt    = qlen_r;
    link_nxt    = link_r;
    wlock_nxt   = wlock_r;
    waiting_nxt = waiting_r;
    dead_nxt    = dead_r;
    req_nxt     = req_r;
    p_nxt       = p_r;
    l_nxt       = l_r;
    step_nxt    = step_r;
    seen_nxt    = seen_r;
    ovalid_nxt  = ovalid_r && out_stall;
    ostatus_nxt = ostatus_r;
    owoken_nxt  = owoken_r;
    omember_nxt = omember_r;
    olast_nxt   = olast_r;
    pop         = 1'b0;

    unique case (state_r)
      // take next word from the queue
      S_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          req_nxt   = head.req;
          state_nxt = S_EXEC;
        end
      end

      // carry out the command on the lock tables
      S_EXEC: begin
        if (slot_free) begin
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_GRANTED;
          owoken_nxt  = '0;
          omember_nxt = '0;
          olast_nxt   = 1'b1;
          state_nxt   = S_IDLE;
          if (req_r.cmd == CMD_RELEASE) begin
            if (!held_r[req_r.lk] || owner_r[req_r.lk] != req_r.pid) begin
              ostatus_nxt = ST_NOT_OWN;
            end else if (qlen_r[req_r.lk] == '0) begin
              held_nxt[req_r.lk] = 1'b0;
              ostatus_nxt        = ST_FREED;
            end else begin
              qlen_nxt[req_r.lk]  = qlen_r[req_r.lk] - QLEN_W'(1);
              if (qlen_r[req_r.lk] != QLEN_W'(1)) qhead_nxt[req_r.lk] = link_r[h];
              owner_nxt[req_r.lk] = h;
              waiting_nxt[h]      = 1'b0;
              ostatus_nxt         = ST_HANDED;
              owoken_nxt          = ID_W'(h);
            end
          end else if (!held_r[req_r.lk]) begin
            held_nxt[req_r.lk]  = 1'b1;
            owner_nxt[req_r.lk] = req_r.pid;
          end else if (req_r.cmd == CMD_TRY
                       || qlen_r[req_r.lk] >= QLEN_W'(NUM_PROCS)) begin
            ostatus_nxt = ST_TRY_FAIL;
          end else begin
            // enqueue and start the chain walk
            if (qlen_r[req_r.lk] == '0) qhead_nxt[req_r.lk] = req_r.pid;
            else link_nxt[qtail_r[req_r.lk]] = req_r.pid;
            qtail_nxt[req_r.lk]    = req_r.pid;
            qlen_nxt[req_r.lk]     = qlen_r[req_r.lk] + QLEN_W'(1);
            waiting_nxt[req_r.pid] = 1'b1;
            wlock_nxt[req_r.pid]   = req_r.lk;
            ovalid_nxt = ovalid_r && out_stall;
            p_nxt      = req_r.pid;
            l_nxt      = req_r.lk;
            step_nxt   = '0;
            seen_nxt   = '0;
            state_nxt  = S_WALK;
          end
        end
      end

      // one link of the owner -> waited-lock chain per cycle while the output slot is free
      S_WALK: begin
        if (slot_free) begin
          if (dead_r[p_r]) begin
            state_nxt = S_IDLE;
          end else begin
            seen_nxt[p_r] = 1'b1;
            if (own == req_r.pid) begin
              state_nxt = S_MARK;
            end else if (!waiting_r[own] || step_r == STEP_W'(NUM_PROCS - 1)) begin
              state_nxt = S_IDLE;
            end else begin
              p_nxt    = own;
              l_nxt    = wlock_r[own];
              step_nxt = step_r + STEP_W'(1);
            end
          end
          if (state_nxt == S_IDLE) begin
            ovalid_nxt  = 1'b1;
            ostatus_nxt = ST_QUEUED;
            owoken_nxt  = '0;
            omember_nxt = '0;
            olast_nxt   = 1'b1;
          end
        end
      end

      // mark every member of the cycle
      S_MARK: begin
        dead_nxt  = dead_r | seen_r;
        state_nxt = S_EMIT;
      end

      // emit members in ascending id order
      S_EMIT: begin
        if (slot_free) begin
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_MEMBER;
          owoken_nxt  = '0;
          omember_nxt = ID_W'(low_idx);
          olast_nxt   = (seen_left == '0);
          seen_nxt    = seen_left;
          if (seen_left == '0) state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    link_r    <= link_nxt;
    req_r     <= req_nxt;
    p_r       <= p_nxt;
    l_r       <= l_nxt;
    step_r    <= step_nxt;
    seen_r    <= seen_nxt;
    ostatus_r <= ostatus_nxt;
    owoken_r  <= owoken_nxt;
    omember_r <= omember_nxt;
    olast_r   <= olast_nxt;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ovalid_r  <= 1'b0;
      held_r    <= '0;
      waiting_r <= '0;
      dead_r    <= '0;
      for (int i = 0; i < NUM_LOCKS; i++) begin
        owner_r[i] <= '0;
        qhead_r[i] <= '0;
        qtail_r[i] <= '0;
        qlen_r[i]  <= '0;
      end
      for (int i = 0; i < NUM_PROCS; i++) begin
        wlock_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      ovalid_r  <= ovalid_nxt;
      held_r    <= held_nxt;
      waiting_r <= waiting_nxt;
      dead_r    <= dead_nxt;
      owner_r   <= owner_nxt;
      qhead_r   <= qhead_nxt;
      qtail_r   <= qtail_nxt;
      qlen_r    <= qlen_nxt;
      wlock_r   <= wlock_nxt;
    end
  end

endmodule

// ===== rtl/lmdd_checker.sv =====
// Port-level checks of the lock manager and their bind to the top level.
module lmdd_checker import lmdd_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input logic [ST_W-1:0] out_status,
  input logic [ID_W-1:0] out_woken_pid,
  input logic [ID_W-1:0] out_member_pid,
  input logic            out_last
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_member_pid) && $stable(out_last))
    else $error("stalled result changed");

  // only member results may be non-final
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_MEMBER |-> out_last)
    else $error("single result without last");

  // member id only on member results, woken id only on handover
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_MEMBER || out_member_pid == '0)
      && (out_status == ST_HANDED || out_woken_pid == '0))
    else $error("stray id field");

  // members of one deadlock come out in ascending order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_status == ST_MEMBER && !out_last ##1 out_valid
      |-> out_status == ST_MEMBER && out_member_pid > $past(out_member_pid))
    else $error("members out of order");

endmodule

bind lock_manager_deadlock_detect lmdd_checker u_lmdd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_woken_pid  (out_woken_pid),
  .out_member_pid (out_member_pid),
  .out_last       (out_last)
);

// ===== sim/lock_manager_deadlock_detect_tb.sv =====
// Testbench for the lock manager with deadlock detection: random and directed requests.
module lock_manager_deadlock_detect_tb;
  import lmdd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_OFF = 400;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  pid;
    logic [ID_W-1:0]  lk;
  } lock_req_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] woken;
    logic [ID_W-1:0] member;
    logic            last;
  } lock_res_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CMD_W-1:0] in_command = CMD_NONE;
  logic [ID_W-1:0]  in_process_id = '0;
  logic [ID_W-1:0]  in_lock_id = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ST_W-1:0]  out_status;
  logic [ID_W-1:0]  out_woken_pid;
  logic [ID_W-1:0]  out_member_pid;
  logic             out_last;

  lock_manager_deadlock_detect uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic            held      [NUM_LOCKS];
  logic [ID_W-1:0] owner     [NUM_LOCKS];
  logic [ID_W-1:0] q_head    [NUM_LOCKS];
  logic [ID_W-1:0] q_tail    [NUM_LOCKS];
  int              q_len     [NUM_LOCKS];
  logic [ID_W-1:0] next_pid  [NUM_PROCS];
  logic [ID_W-1:0] waits_on  [NUM_PROCS];
  logic            waiting   [NUM_PROCS];
  logic            deadlocked[NUM_PROCS];

  lock_req_t pending_reqs[$];
  lock_res_t expected_res[$];
  int cyc = 0;
  int errors = 0;
  int n_results = 0, n_members = 0, n_handed = 0, n_full = 0, n_accepted = 0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  function automatic void push_res(logic [ST_W-1:0] st, logic [ID_W-1:0] w,
                                   logic [ID_W-1:0] m, logic lst);
    lock_res_t r;
    r.status = st;
    r.woken = w;
    r.member = m;
    r.last = lst;
    expected_res.push_back(r);
  endfunction

  // Update the lock tables for one accepted word and queue what it answers.
  function automatic void predict_lock(lock_req_t rq);
    logic [ID_W-1:0] p, l, pp, ll, own, h;
    logic [NUM_PROCS-1:0] seen;
    bit found;
    int cnt, k;
    p = rq.pid;
    l = rq.lk;
    found = 1'b0;
    seen = '0;
    cnt = 0;
    k = 0;
    if (rq.cmd == CMD_NONE) return;
    if (rq.cmd == CMD_RELEASE) begin
      if (!held[l] || owner[l] != p) begin
        push_res(ST_NOT_OWN, '0, '0, 1'b1);
      end else if (q_len[l] == 0) begin
        held[l] = 1'b0;
        push_res(ST_FREED, '0, '0, 1'b1);
      end else begin
        h = q_head[l];
        q_len[l]--;
        if (q_len[l] != 0) q_head[l] = next_pid[h];
        owner[l] = h;
        waiting[h] = 1'b0;
        push_res(ST_HANDED, h, '0, 1'b1);
      end
      return;
    end
    if (!held[l]) begin
      held[l] = 1'b1;
      owner[l] = p;
      push_res(ST_GRANTED, '0, '0, 1'b1);
      return;
    end
    if (rq.cmd == CMD_TRY || q_len[l] >= NUM_PROCS) begin
      if (rq.cmd != CMD_TRY) n_full++;
      push_res(ST_TRY_FAIL, '0, '0, 1'b1);
      return;
    end
    // join the lock's queue
    if (q_len[l] == 0) q_head[l] = p;
    else next_pid[q_tail[l]] = p;
    q_tail[l] = p;
    q_len[l]++;
    waiting[p] = 1'b1;
    waits_on[p] = l;
    // walk the owner chain
    pp = p;
    ll = l;
    for (int step = 0; step < NUM_PROCS; step++) begin
      if (deadlocked[pp]) break;
      seen[pp] = 1'b1;
      own = owner[ll];
      if (own == p) begin
        found = 1'b1;
        break;
      end
      if (!waiting[own]) break;
      pp = own;
      ll = waits_on[own];
    end
    if (!found) begin
      push_res(ST_QUEUED, '0, '0, 1'b1);
      return;
    end
    for (int i = 0; i < NUM_PROCS; i++)
      if (seen[i]) begin
        deadlocked[i] = 1'b1;
        cnt++;
      end
    for (int i = 0; i < NUM_PROCS; i++)
      if (seen[i]) begin
        k++;
        push_res(ST_MEMBER, '0, ID_W'(i), k == cnt);
      end
  endfunction

  function automatic void add_req(int c, int p, int l);
    lock_req_t rq;
    rq.cmd = CMD_W'(c);
    rq.pid = ID_W'(p);
    rq.lk = ID_W'(l);
    pending_reqs.push_back(rq);
  endfunction

  // Drive request words; advance on accept, hold while stalled.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_lock({in_command, in_process_id, in_lock_id});
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 &&
            ((cyc > 2000 && cyc < 4000) || $urandom_range(99) >= 20)) begin
          in_valid <= 1'b1;
          {in_command, in_process_id, in_lock_id} <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Hold the result side off once for a long stretch.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted > 150) begin
      hold_left <= HOLD_OFF;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_stall <= (hold_left > 1) ||
                 (!(cyc > 2000 && cyc < 4000) && $urandom_range(99) < 20);
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin
    lock_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results <= n_results + 1;
      if (out_status == ST_MEMBER) n_members <= n_members + 1;
      if (out_status == ST_HANDED) n_handed <= n_handed + 1;
      if (expected_res.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10)
          $display("unexpected result: status %0d woken %0d member %0d last %0b",
                   out_status, out_woken_pid, out_member_pid, out_last);
      end else begin
        want = expected_res.pop_front();
        if (want != {out_status, out_woken_pid, out_member_pid, out_last}) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: want st %0d w %0d m %0d l %0b, got st %0d w %0d m %0d l %0b",
                     want.status, want.woken, want.member, want.last,
                     out_status, out_woken_pid, out_member_pid, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("lock_manager_deadlock_detect_tb failed");
      $finish;
    end
  end

  initial begin
    int k, c, p, l, sel, base;
    int pids[5];
    for (int i = 0; i < NUM_LOCKS; i++) begin
      held[i] = 1'b0; owner[i] = '0; q_head[i] = '0; q_tail[i] = '0; q_len[i] = 0;
    end
    for (int i = 0; i < NUM_PROCS; i++) begin
      next_pid[i] = '0; waits_on[i] = '0; waiting[i] = 1'b0; deadlocked[i] = 1'b0;
    end
    // directed: grant, try fail, two not-owner releases, unused command, grant
    add_req(CMD_ACQUIRE, 0, 0);
    add_req(CMD_TRY, 1, 0);
    add_req(CMD_RELEASE, 1, 0);
    add_req(CMD_RELEASE, 0, 15);
    add_req(CMD_NONE, 5, 5);
    add_req(CMD_ACQUIRE, 15, 15);
    // queue two waiters, hand over twice, then free
    add_req(CMD_ACQUIRE, 1, 0);
    add_req(CMD_ACQUIRE, 2, 0);
    add_req(CMD_RELEASE, 0, 0);
    add_req(CMD_RELEASE, 1, 0);
    add_req(CMD_RELEASE, 2, 0);
    // two-process deadlock
    add_req(CMD_TRY, 3, 3);
    add_req(CMD_ACQUIRE, 4, 4);
    add_req(CMD_ACQUIRE, 3, 4);
    add_req(CMD_ACQUIRE, 4, 3);
    // owner waits on its own lock
    add_req(CMD_ACQUIRE, 15, 15);
    add_req(CMD_RELEASE, 15, 15);
    add_req(CMD_TRY, 7, 15);
    // random part: mostly well-formed sequences, some noise
    while (pending_reqs.size() < 445) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        // chain that closes into a cycle, then unwind
        k = $urandom_range(5, 2);
        base = $urandom_range(15);
        for (int i = 0; i < k; i++) pids[i] = $urandom_range(15);
        for (int i = 0; i < k; i++) add_req(CMD_ACQUIRE, pids[i], (base + i) % 16);
        for (int i = 0; i < k; i++) add_req(CMD_ACQUIRE, pids[i], (base + (i + 1) % k) % 16);
        for (int i = 0; i < k; i++) add_req(CMD_RELEASE, pids[i], (base + i) % 16);
      end else if (sel < 65) begin
        // contention on one lock
        l = $urandom_range(15);
        k = $urandom_range(4, 1);
        for (int i = 0; i < k; i++)
          add_req($urandom_range(1) ? CMD_ACQUIRE : CMD_TRY, $urandom_range(15), l);
        for (int i = 0; i < k; i++) add_req(CMD_RELEASE, $urandom_range(15), l);
      end else if (sel < 67) begin
        // fill one queue past its limit
        l = $urandom_range(15);
        for (int i = 0; i < 18; i++) add_req(CMD_ACQUIRE, $urandom_range(15), l);
      end else begin
        c = $urandom_range(3);
        p = $urandom_range(15);
        l = $urandom_range(15);
        add_req(c, p, l);
      end
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d requests, %0d results: %0d deadlock members, %0d hand-overs,",
             n_accepted, n_results, n_members, n_handed);
    $display("%0d full-queue refusals, one long output hold-off, %0d errors",
             n_full, errors);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("lock_manager_deadlock_detect_tb passed");
    end else begin
      $display("lock_manager_deadlock_detect_tb failed");
    end
    $finish;
  end

endmodule
